// ----- src/tpnme_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and Q16.16 saturating helpers for the two-phase node
// momentum exchange block. No dependencies.
package tpnme_pkg;

    typedef logic signed [31:0] q_t;

    // value plus a flag that the step clipped
    typedef struct packed {
        q_t   val;
        logic clip;
    } qres_t;

    localparam q_t Q_MAX = 32'sh7FFF_FFFF;
    localparam q_t Q_MIN = 32'sh8000_0000;

    // phase mode, encoded as {water_active, sand_active}
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_SAND  = 2'd1;
    localparam logic [1:0] MODE_WATER = 2'd2;
    localparam logic [1:0] MODE_BOTH  = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_TIME_STEP   = 3'd0;
    localparam logic [2:0] CFG_GRAVITY_X   = 3'd1;
    localparam logic [2:0] CFG_GRAVITY_Y   = 3'd2;
    localparam logic [2:0] CFG_COUPLED_G_Y = 3'd3;
    localparam logic [2:0] CFG_DRAG_COEFF  = 3'd4;

    // divider: one quotient bit per stage, plus prep and sign/saturate stages
    localparam int DIV_BITS = 48;
    localparam int DIV_LAT  = DIV_BITS + 2;

    typedef struct packed {
        logic [16:0] time_step;
        q_t          gravity_x;
        q_t          gravity_y;
        q_t          coupled_gravity_y;
        logic [30:0] drag_coeff;
    } tpnme_cfg_t;

    typedef struct packed {
        logic        sand_active;
        logic        water_active;
        logic [30:0] sand_mass;
        logic [30:0] water_mass;
        q_t          sand_vel_x;
        q_t          sand_vel_y;
        q_t          water_vel_x;
        q_t          water_vel_y;
        q_t          sand_force_x;
        q_t          sand_force_y;
        q_t          water_force_x;
        q_t          water_force_y;
    } tpnme_in_t;

    // control and single-phase data that rides alongside the divider
    typedef struct packed {
        logic       valid;
        logic [1:0] mode;
        logic       clip;
        q_t         vx;
        q_t         vy;
    } tpnme_side_t;

    typedef struct packed {
        logic valid;
        q_t   sand_new_vx;
        q_t   sand_new_vy;
        q_t   water_new_vx;
        q_t   water_new_vy;
        logic sand_valid;
        logic water_valid;
        logic cohesion_flag;
        logic saturated;
    } tpnme_res_t;

    function automatic qres_t q_add(q_t a, q_t b);
        logic signed [32:0] s;
        qres_t r;
        s = 33'(a) + 33'(b);
        r.clip = (s[32] != s[31]);
        r.val  = r.clip ? (s[32] ? Q_MIN : Q_MAX) : q_t'(s[31:0]);
        return r;
    endfunction

    function automatic qres_t q_sub(q_t a, q_t b);
        logic signed [32:0] s;
        qres_t r;
        s = 33'(a) - 33'(b);
        r.clip = (s[32] != s[31]);
        r.val  = r.clip ? (s[32] ? Q_MIN : Q_MAX) : q_t'(s[31:0]);
        return r;
    endfunction

    // full product, floor shift by 16, saturate
    function automatic qres_t q_mul(q_t a, q_t b);
        logic signed [63:0] p;
        logic signed [63:0] sh;
        logic ok;
        qres_t r;
        p  = 64'(a) * 64'(b);
        sh = p >>> 16;
        ok = (sh[63:31] == '0) || (sh[63:31] == '1);
        r.clip = !ok;
        r.val  = ok ? q_t'(sh[31:0]) : (sh[63] ? Q_MIN : Q_MAX);
        return r;
    endfunction

endpackage

// ----- src/tpnme_front.sv -----
`timescale 1ns / 1ps
// Front end: eight stages that build the coupled 2x2 system and its
// numerators and determinant, or pass single-phase operands. Uses tpnme_pkg.
module tpnme_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    ce,
    input  logic                    in_valid,
    input  tpnme_pkg::tpnme_in_t    in_word,
    input  tpnme_pkg::tpnme_cfg_t   cfg,
    output tpnme_pkg::q_t           div_num [4],
    output tpnme_pkg::q_t           div_den [4],
    output tpnme_pkg::tpnme_side_t  side
);
    import tpnme_pkg::*;

    typedef struct packed {
        q_t m;
        q_t fx;
        q_t fy;
        q_t vx;
        q_t vy;
    } sg_t;

    q_t dt_q, drag_q, ms_in, mw_in;
    assign dt_q   = q_t'({15'd0, cfg.time_step});
    assign drag_q = q_t'({1'b0, cfg.drag_coeff});
    assign ms_in  = q_t'({1'b0, in_word.sand_mass});
    assign mw_in  = q_t'({1'b0, in_word.water_mass});

    // control along the stages
    logic [7:0] vld_reg;
    logic [1:0] mode_reg [7];
    logic       clip_reg [7];
    sg_t        sg_reg [7];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[6:0], in_valid};
        end
    end

    // ---------------- stage 1: first products
    logic [1:0] mode_next;
    logic       b0;
    sg_t        sg_next;
    qres_t      mw2_next, msvx_next, msvy_next, mwvx_next, mwvy_next;
    qres_t      dtsfx_next, dtwfx_next, msgc_next, mwgc_next;
    logic       clip1_next;

    assign mode_next  = {in_word.water_active, in_word.sand_active};
    assign b0         = (mode_next == MODE_BOTH);
    assign mw2_next   = q_mul(mw_in, mw_in);
    assign msvx_next  = q_mul(ms_in, in_word.sand_vel_x);
    assign msvy_next  = q_mul(ms_in, in_word.sand_vel_y);
    assign mwvx_next  = q_mul(mw_in, in_word.water_vel_x);
    assign mwvy_next  = q_mul(mw_in, in_word.water_vel_y);
    assign dtsfx_next = q_mul(dt_q, in_word.sand_force_x);
    assign dtwfx_next = q_mul(dt_q, in_word.water_force_x);
    assign msgc_next  = q_mul(ms_in, cfg.coupled_gravity_y);
    assign mwgc_next  = q_mul(mw_in, cfg.coupled_gravity_y);
    assign clip1_next = b0 & (mw2_next.clip | msvx_next.clip | msvy_next.clip
                      | mwvx_next.clip | mwvy_next.clip | dtsfx_next.clip
                      | dtwfx_next.clip | msgc_next.clip | mwgc_next.clip);

    // single phase picks its own operands
    always_comb
    begin
        if (mode_next == MODE_WATER)
        begin
            sg_next = '{m: mw_in, fx: in_word.water_force_x, fy: in_word.water_force_y,
                        vx: in_word.water_vel_x, vy: in_word.water_vel_y};
        end
        else
        begin
            sg_next = '{m: ms_in, fx: in_word.sand_force_x, fy: in_word.sand_force_y,
                        vx: in_word.sand_vel_x, vy: in_word.sand_vel_y};
        end
    end

    q_t ms_reg [5];
    q_t mw_reg [5];
    q_t mw2_reg, msvx_reg, mwvx_reg, dtsfx_reg, dtwfx_reg, msgc_reg, mwgc_reg;
    q_t sfy_reg, wfy_reg;
    q_t msvy_reg [3];
    q_t mwvy_reg [3];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            mode_reg[0] <= mode_next;
            clip_reg[0] <= clip1_next;
            sg_reg[0]   <= sg_next;
            ms_reg[0]   <= ms_in;
            mw_reg[0]   <= mw_in;
            mw2_reg     <= mw2_next.val;
            msvx_reg    <= msvx_next.val;
            msvy_reg[0] <= msvy_next.val;
            mwvx_reg    <= mwvx_next.val;
            mwvy_reg[0] <= mwvy_next.val;
            dtsfx_reg   <= dtsfx_next.val;
            dtwfx_reg   <= dtwfx_next.val;
            msgc_reg    <= msgc_next.val;
            mwgc_reg    <= mwgc_next.val;
            sfy_reg     <= in_word.sand_force_y;
            wfy_reg     <= in_word.water_force_y;
            for (int k = 1; k < 7; k++)
            begin
                mode_reg[k] <= mode_reg[k-1];
                sg_reg[k]   <= sg_reg[k-1];
            end
            for (int k = 1; k < 5; k++)
            begin
                ms_reg[k] <= ms_reg[k-1];
                mw_reg[k] <= mw_reg[k-1];
            end
            for (int k = 1; k < 3; k++)
            begin
                msvy_reg[k] <= msvy_reg[k-1];
                mwvy_reg[k] <= mwvy_reg[k-1];
            end
        end
    end

    // ---------------- stage 2: Ms*Mw^2, right-hand x terms
    logic  b1;
    qres_t p2_next, b0x_next, b1x_next, t0y_next, t1y_next;
    assign b1       = (mode_reg[0] == MODE_BOTH);
    assign p2_next  = q_mul(ms_reg[0], mw2_reg);
    assign b0x_next = q_sub(msvx_reg, dtsfx_reg);
    assign b1x_next = q_sub(mwvx_reg, dtwfx_reg);
    assign t0y_next = q_sub(msgc_reg, sfy_reg);
    assign t1y_next = q_sub(mwgc_reg, wfy_reg);

    q_t p2_reg, t0y_reg, t1y_reg;
    q_t b0x_reg [5];
    q_t b1x_reg [5];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            clip_reg[1] <= clip_reg[0] | (b1 & (p2_next.clip | b0x_next.clip
                         | b1x_next.clip | t0y_next.clip | t1y_next.clip));
            p2_reg     <= p2_next.val;
            t0y_reg    <= t0y_next.val;
            t1y_reg    <= t1y_next.val;
            b0x_reg[0] <= b0x_next.val;
            b1x_reg[0] <= b1x_next.val;
            for (int k = 1; k < 5; k++)
            begin
                b0x_reg[k] <= b0x_reg[k-1];
                b1x_reg[k] <= b1x_reg[k-1];
            end
        end
    end

    // ---------------- stage 3: drag product, dt*(M*g - F)
    logic  b2;
    qres_t p3_next, dt0_next, dt1_next;
    assign b2       = (mode_reg[1] == MODE_BOTH);
    assign p3_next  = q_mul(drag_q, p2_reg);
    assign dt0_next = q_mul(dt_q, t0y_reg);
    assign dt1_next = q_mul(dt_q, t1y_reg);

    q_t p3_reg, dt0_reg, dt1_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            clip_reg[2] <= clip_reg[1] | (b2 & (p3_next.clip | dt0_next.clip
                         | dt1_next.clip));
            p3_reg  <= p3_next.val;
            dt0_reg <= dt0_next.val;
            dt1_reg <= dt1_next.val;
        end
    end

    // ---------------- stage 4: d = -drag*Ms*Mw^2, right-hand y terms
    logic  b3;
    qres_t d_next, b0y_next, b1y_next;
    assign b3       = (mode_reg[2] == MODE_BOTH);
    assign d_next   = q_sub('0, p3_reg);
    assign b0y_next = q_add(msvy_reg[2], dt0_reg);
    assign b1y_next = q_add(mwvy_reg[2], dt1_reg);

    q_t d_reg;
    q_t b0y_reg [3];
    q_t b1y_reg [3];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            clip_reg[3] <= clip_reg[2] | (b3 & (d_next.clip | b0y_next.clip
                         | b1y_next.clip));
            d_reg      <= d_next.val;
            b0y_reg[0] <= b0y_next.val;
            b1y_reg[0] <= b1y_next.val;
            for (int k = 1; k < 3; k++)
            begin
                b0y_reg[k] <= b0y_reg[k-1];
                b1y_reg[k] <= b1y_reg[k-1];
            end
        end
    end

    // ---------------- stage 5: e = dt*d
    logic  b4;
    qres_t e_next;
    assign b4     = (mode_reg[3] == MODE_BOTH);
    assign e_next = q_mul(dt_q, d_reg);

    q_t e5_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            clip_reg[4] <= clip_reg[3] | (b4 & e_next.clip);
            e5_reg      <= e_next.val;
        end
    end

    // ---------------- stage 6: diagonal of the system
    logic  b5;
    qres_t a00_next, a11_next;
    assign b5       = (mode_reg[4] == MODE_BOTH);
    assign a00_next = q_sub(ms_reg[4], e5_reg);
    assign a11_next = q_sub(mw_reg[4], e5_reg);

    q_t a00_reg, a11_reg, e6_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            clip_reg[5] <= clip_reg[4] | (b5 & (a00_next.clip | a11_next.clip));
            a00_reg     <= a00_next.val;
            a11_reg     <= a11_next.val;
            e6_reg      <= e5_reg;
        end
    end

    // ---------------- stage 7: cofactor products
    logic  b6;
    qres_t aa_next, ee_next;
    qres_t na_next [4];
    qres_t nb_next [4];
    assign b6         = (mode_reg[5] == MODE_BOTH);
    assign aa_next    = q_mul(a00_reg, a11_reg);
    assign ee_next    = q_mul(e6_reg, e6_reg);
    assign na_next[0] = q_mul(a11_reg, b0x_reg[4]);
    assign nb_next[0] = q_mul(e6_reg, b1x_reg[4]);
    assign na_next[1] = q_mul(a11_reg, b0y_reg[2]);
    assign nb_next[1] = q_mul(e6_reg, b1y_reg[2]);
    assign na_next[2] = q_mul(a00_reg, b1x_reg[4]);
    assign nb_next[2] = q_mul(e6_reg, b0x_reg[4]);
    assign na_next[3] = q_mul(a00_reg, b1y_reg[2]);
    assign nb_next[3] = q_mul(e6_reg, b0y_reg[2]);

    logic clip7_next;
    always_comb
    begin
        clip7_next = aa_next.clip | ee_next.clip;
        for (int k = 0; k < 4; k++)
        begin
            clip7_next = clip7_next | na_next[k].clip | nb_next[k].clip;
        end
    end

    q_t aa_reg, ee_reg;
    q_t na_reg [4];
    q_t nb_reg [4];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            clip_reg[6] <= clip_reg[5] | (b6 & clip7_next);
            aa_reg      <= aa_next.val;
            ee_reg      <= ee_next.val;
            for (int k = 0; k < 4; k++)
            begin
                na_reg[k] <= na_next[k].val;
                nb_reg[k] <= nb_next[k].val;
            end
        end
    end

    // ---------------- stage 8: determinant, numerators, divider operands
    logic  b7, single7;
    qres_t det_next;
    qres_t num_next [4];
    logic  clip8_next;
    sg_t   sg7;
    assign b7       = (mode_reg[6] == MODE_BOTH);
    assign single7  = (mode_reg[6] == MODE_SAND) || (mode_reg[6] == MODE_WATER);
    assign sg7      = sg_reg[6];
    assign det_next = q_sub(aa_reg, ee_reg);

    always_comb
    begin
        clip8_next = det_next.clip;
        for (int k = 0; k < 4; k++)
        begin
            num_next[k] = q_sub(na_reg[k], nb_reg[k]);
            clip8_next  = clip8_next | num_next[k].clip;
        end
    end

    q_t          num_reg [4];
    q_t          den_reg [4];
    tpnme_side_t side_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            // single phase: lanes 0 and 1 divide force by mass
            num_reg[0] <= single7 ? sg7.fx : num_next[0].val;
            num_reg[1] <= single7 ? sg7.fy : num_next[1].val;
            den_reg[0] <= single7 ? sg7.m  : det_next.val;
            den_reg[1] <= single7 ? sg7.m  : det_next.val;
            num_reg[2] <= num_next[2].val;
            num_reg[3] <= num_next[3].val;
            den_reg[2] <= det_next.val;
            den_reg[3] <= det_next.val;
            side_reg   <= '{valid: 1'b0, mode: mode_reg[6],
                            clip: clip_reg[6] | (b7 & clip8_next),
                            vx: sg7.vx, vy: sg7.vy};
        end
    end

    assign div_num = num_reg;
    assign div_den = den_reg;

    always_comb
    begin
        side       = side_reg;
        side.valid = vld_reg[7];
    end

endmodule

// ----- src/tpnme_div_lane.sv -----
`timescale 1ns / 1ps
// One lane of the pipelined signed divider: (num * 2^16) / den, truncated
// toward zero and saturated, one quotient bit per stage. Uses tpnme_pkg.
module tpnme_div_lane (
    input  logic          clk,
    input  logic          ce,
    input  tpnme_pkg::q_t num,
    input  tpnme_pkg::q_t den,
    output tpnme_pkg::q_t quo,
    output logic          clip
);
    import tpnme_pkg::*;

    typedef struct packed {
        logic neg;
        logic dzero;
        logic nneg;
        logic nzero;
    } flags_t;

    // rq: dividend bits shifting out the top, quotient bits shifting in
    logic [DIV_BITS-1:0] rq_reg [DIV_BITS+1];
    logic [31:0]         r_reg  [DIV_BITS+1];
    logic [31:0]         dm_reg [DIV_BITS+1];
    flags_t              fl_reg [DIV_BITS+1];

    // prep: magnitudes and sign
    logic [31:0] nmag_next, dmag_next;
    assign nmag_next = num[31] ? (~num + 32'd1) : num;
    assign dmag_next = den[31] ? (~den + 32'd1) : den;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rq_reg[0] <= {nmag_next, 16'd0};
            r_reg[0]  <= '0;
            dm_reg[0] <= dmag_next;
            fl_reg[0] <= '{neg: num[31] ^ den[31], dzero: (den == '0),
                           nneg: num[31], nzero: (num == '0)};
        end
    end

    // restoring steps
    for (genvar k = 1; k <= DIV_BITS; k++)
    begin : g_step
        logic [33:0] diff_next;
        logic        ge_next;
        assign diff_next = {1'b0, r_reg[k-1], rq_reg[k-1][DIV_BITS-1]}
                         - {2'b00, dm_reg[k-1]};
        assign ge_next   = !diff_next[33];

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                r_reg[k]  <= ge_next ? diff_next[31:0]
                                     : {r_reg[k-1][30:0], rq_reg[k-1][DIV_BITS-1]};
                rq_reg[k] <= {rq_reg[k-1][DIV_BITS-2:0], ge_next};
                dm_reg[k] <= dm_reg[k-1];
                fl_reg[k] <= fl_reg[k-1];
            end
        end
    end

    // sign, saturation and zero divisor
    logic [DIV_BITS-1:0] mag;
    flags_t              fl;
    q_t                  quo_next;
    logic                clip_next;
    assign mag = rq_reg[DIV_BITS];
    assign fl  = fl_reg[DIV_BITS];

    always_comb
    begin
        quo_next  = '0;
        clip_next = 1'b0;
        if (fl.dzero)
        begin
            clip_next = 1'b1;
            if (fl.nzero)
            begin
                quo_next = '0;
            end
            else
            begin
                quo_next = fl.nneg ? Q_MIN : Q_MAX;
            end
        end
        else if (!fl.neg)
        begin
            if (mag > DIV_BITS'(32'h7FFF_FFFF))
            begin
                quo_next  = Q_MAX;
                clip_next = 1'b1;
            end
            else
            begin
                quo_next = q_t'(mag[31:0]);
            end
        end
        else
        begin
            if (mag > DIV_BITS'(32'h8000_0000))
            begin
                quo_next  = Q_MIN;
                clip_next = 1'b1;
            end
            else
            begin
                quo_next = q_t'(~mag[31:0] + 32'd1);
            end
        end
    end

    q_t   quo_reg;
    logic clip_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            quo_reg  <= quo_next;
            clip_reg <= clip_next;
        end
    end

    assign quo  = quo_reg;
    assign clip = clip_reg;

endmodule

// ----- src/tpnme_side_delay.sv -----
`timescale 1ns / 1ps
// Shift line that carries mode, clip and single-phase velocity past the
// divider lanes, matched to their latency. Uses tpnme_pkg.
module tpnme_side_delay (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   ce,
    input  tpnme_pkg::tpnme_side_t side_in,
    output tpnme_pkg::tpnme_side_t side_out
);
    import tpnme_pkg::*;

    logic [DIV_LAT-1:0] vld_reg;
    tpnme_side_t        pay_reg [DIV_LAT];

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[DIV_LAT-2:0], side_in.valid};
        end
    end

    // payload taps
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            pay_reg[0] <= side_in;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                pay_reg[k] <= pay_reg[k-1];
            end
        end
    end

    always_comb
    begin
        side_out       = pay_reg[DIV_LAT-1];
        side_out.valid = vld_reg[DIV_LAT-1];
    end

endmodule

// ----- src/tpnme_post.sv -----
`timescale 1ns / 1ps
// Back end: finishes the single-phase update v + dt*(g - F/m) in three
// stages and routes coupled quotients to the result word. Uses tpnme_pkg.
module tpnme_post (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   ce,
    input  tpnme_pkg::q_t          quo [4],
    input  logic                   quo_clip [4],
    input  tpnme_pkg::tpnme_side_t side,
    input  tpnme_pkg::tpnme_cfg_t  cfg,
    output tpnme_pkg::tpnme_res_t  res
);
    import tpnme_pkg::*;

    q_t dt_q;
    assign dt_q = q_t'({15'd0, cfg.time_step});

    logic [2:0] vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[1:0], side.valid};
        end
    end

    // ---------------- stage 1: g - F/m
    logic  both0, single0;
    qres_t s0_next, s1_next;
    logic  clip1_next;
    assign both0   = (side.mode == MODE_BOTH);
    assign single0 = (side.mode == MODE_SAND) || (side.mode == MODE_WATER);
    assign s0_next = q_sub(cfg.gravity_x, quo[0]);
    assign s1_next = q_sub(cfg.gravity_y, quo[1]);
    assign clip1_next = side.clip
        | (single0 & (quo_clip[0] | quo_clip[1] | s0_next.clip | s1_next.clip))
        | (both0 & (quo_clip[0] | quo_clip[1] | quo_clip[2] | quo_clip[3]));

    logic [1:0] mode_reg [3];
    logic       clip_reg [3];
    q_t         q_reg [2][4];
    q_t         vx_reg [2];
    q_t         vy_reg [2];
    q_t         s0_reg, s1_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            mode_reg[0] <= side.mode;
            clip_reg[0] <= clip1_next;
            q_reg[0]    <= quo;
            vx_reg[0]   <= side.vx;
            vy_reg[0]   <= side.vy;
            s0_reg      <= s0_next.val;
            s1_reg      <= s1_next.val;
        end
    end

    // ---------------- stage 2: dt*(g - F/m)
    logic  single1;
    qres_t m0_next, m1_next;
    assign single1 = (mode_reg[0] == MODE_SAND) || (mode_reg[0] == MODE_WATER);
    assign m0_next = q_mul(dt_q, s0_reg);
    assign m1_next = q_mul(dt_q, s1_reg);

    q_t m0_reg, m1_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            mode_reg[1] <= mode_reg[0];
            clip_reg[1] <= clip_reg[0] | (single1 & (m0_next.clip | m1_next.clip));
            q_reg[1]    <= q_reg[0];
            vx_reg[1]   <= vx_reg[0];
            vy_reg[1]   <= vy_reg[0];
            m0_reg      <= m0_next.val;
            m1_reg      <= m1_next.val;
        end
    end

    // ---------------- stage 3: v + dt*(...), route to result
    logic  single2;
    qres_t n0_next, n1_next;
    assign single2 = (mode_reg[1] == MODE_SAND) || (mode_reg[1] == MODE_WATER);
    assign n0_next = q_add(vx_reg[1], m0_reg);
    assign n1_next = q_add(vy_reg[1], m1_reg);

    tpnme_res_t res_next;
    always_comb
    begin
        res_next           = '0;
        res_next.saturated = clip_reg[1] | (single2 & (n0_next.clip | n1_next.clip));
        case (mode_reg[1])
            MODE_BOTH:
            begin
                res_next.sand_new_vx   = q_reg[1][0];
                res_next.sand_new_vy   = q_reg[1][1];
                res_next.water_new_vx  = q_reg[1][2];
                res_next.water_new_vy  = q_reg[1][3];
                res_next.sand_valid    = 1'b1;
                res_next.water_valid   = 1'b1;
                res_next.cohesion_flag = 1'b1;
            end
            MODE_SAND:
            begin
                res_next.sand_new_vx = n0_next.val;
                res_next.sand_new_vy = n1_next.val;
                res_next.sand_valid  = 1'b1;
            end
            MODE_WATER:
            begin
                res_next.water_new_vx = n0_next.val;
                res_next.water_new_vy = n1_next.val;
                res_next.water_valid  = 1'b1;
            end
            default:
            begin
                res_next.saturated = 1'b0;
            end
        endcase
    end

    tpnme_res_t res_reg;
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            res_reg <= res_next;
        end
    end

    always_comb
    begin
        res       = res_reg;
        res.valid = vld_reg[2];
    end

endmodule

// ----- src/two_phase_node_momentum_exchange.sv -----
`timescale 1ns / 1ps
// Top level of the two-phase node momentum exchange: configuration registers,
// stream ports, output buffer. Uses tpnme_pkg and the tpnme_* submodules.

// Takes one grid node per cycle while s_axis_tready is high and returns one
// result word per node, in order. The path runs through 8 front stages that
// build the coupled 2x2 system, 50 stages of four parallel dividers (48
// restoring steps, one quotient bit per stage, plus prep and sign/saturate),
// 3 back stages for the single-phase update and one output register. The
// divider chain sets the latency. A skid register behind the output keeps
// accepting while one result waits; s_axis_tready drops only when that skid
// register is full. Configuration writes take effect at once and must be
// made with the pipeline empty. There is no clearing pass after reset.
module two_phase_node_momentum_exchange (
    input  logic         clk,
    input  logic         rst_n,
    // configuration
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    // node input
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: sand_mass, water_mass, sand_vel_x, sand_vel_y, water_vel_x,
    //        water_vel_y, sand_force_x, sand_force_y, water_force_x,
    //        water_force_y, 2 bits zero fill
    input  logic [319:0] s_axis_tdata,
    // tuser: sand_active, water_active
    input  logic [1:0]   s_axis_tuser,
    // result output
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: sand_new_vx, sand_new_vy, water_new_vx, water_new_vy
    output logic [127:0] m_axis_tdata,
    // tuser: sand_valid, water_valid, cohesion_flag, saturated
    output logic [3:0]   m_axis_tuser
);
    import tpnme_pkg::*;

    localparam logic [16:0] DT_RESET   = 17'd66;
    localparam q_t          GX_RESET   = 32'sd0;
    localparam q_t          GY_RESET   = -32'sd196608;
    localparam q_t          GC_RESET   = -32'sd196608;
    localparam logic [30:0] DRAG_RESET = 31'd19661;

    // configuration registers
    tpnme_cfg_t cfg_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{time_step: DT_RESET, gravity_x: GX_RESET, gravity_y: GY_RESET,
                         coupled_gravity_y: GC_RESET, drag_coeff: DRAG_RESET};
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TIME_STEP:   cfg_reg.time_step         <= cfg_wdata[16:0];
                CFG_GRAVITY_X:   cfg_reg.gravity_x         <= q_t'(cfg_wdata);
                CFG_GRAVITY_Y:   cfg_reg.gravity_y         <= q_t'(cfg_wdata);
                CFG_COUPLED_G_Y: cfg_reg.coupled_gravity_y <= q_t'(cfg_wdata);
                CFG_DRAG_COEFF:  cfg_reg.drag_coeff        <= cfg_wdata[30:0];
                default:         ;
            endcase
        end
    end

    // global advance: the whole pipeline moves unless the skid word is held
    logic ce;
    logic skid_valid_reg, out_valid_reg;
    assign ce            = !skid_valid_reg;
    assign s_axis_tready = ce;

    // unpack the input word
    tpnme_in_t in_word;
    always_comb
    begin
        in_word.sand_active   = s_axis_tuser[0];
        in_word.water_active  = s_axis_tuser[1];
        in_word.sand_mass     = s_axis_tdata[30:0];
        in_word.water_mass    = s_axis_tdata[61:31];
        in_word.sand_vel_x    = q_t'(s_axis_tdata[93:62]);
        in_word.sand_vel_y    = q_t'(s_axis_tdata[125:94]);
        in_word.water_vel_x   = q_t'(s_axis_tdata[157:126]);
        in_word.water_vel_y   = q_t'(s_axis_tdata[189:158]);
        in_word.sand_force_x  = q_t'(s_axis_tdata[221:190]);
        in_word.sand_force_y  = q_t'(s_axis_tdata[253:222]);
        in_word.water_force_x = q_t'(s_axis_tdata[285:254]);
        in_word.water_force_y = q_t'(s_axis_tdata[317:286]);
    end

    // front end
    q_t          div_num [4];
    q_t          div_den [4];
    tpnme_side_t side_front;

    tpnme_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .ce       (ce),
        .in_valid (s_axis_tvalid),
        .in_word  (in_word),
        .cfg      (cfg_reg),
        .div_num  (div_num),
        .div_den  (div_den),
        .side     (side_front)
    );

    // divider lanes
    q_t   quo [4];
    logic quo_clip [4];

    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        tpnme_div_lane u_div (
            .clk  (clk),
            .ce   (ce),
            .num  (div_num[g]),
            .den  (div_den[g]),
            .quo  (quo[g]),
            .clip (quo_clip[g])
        );
    end

    tpnme_side_t side_back;
    tpnme_side_delay u_side (
        .clk      (clk),
        .rst_n    (rst_n),
        .ce       (ce),
        .side_in  (side_front),
        .side_out (side_back)
    );

    // back end
    tpnme_res_t res;
    tpnme_post u_post (
        .clk      (clk),
        .rst_n    (rst_n),
        .ce       (ce),
        .quo      (quo),
        .quo_clip (quo_clip),
        .side     (side_back),
        .cfg      (cfg_reg),
        .res      (res)
    );

    // output register plus skid word
    tpnme_res_t out_reg, skid_reg;
    logic       out_load, skid_load, skid_move;
    assign out_load  = ce && (!out_valid_reg || m_axis_tready);
    assign skid_load = ce && out_valid_reg && !m_axis_tready && res.valid;
    assign skid_move = !ce && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= res.valid;
            end
            if (skid_load)
            begin
                skid_valid_reg <= 1'b1;
            end
            else if (skid_move)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= res;
        end
        else if (skid_move)
        begin
            out_reg <= skid_reg;
        end
        if (skid_load)
        begin
            skid_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.water_new_vy, out_reg.water_new_vx,
                            out_reg.sand_new_vy, out_reg.sand_new_vx};
    assign m_axis_tuser  = {out_reg.saturated, out_reg.cohesion_flag,
                            out_reg.water_valid, out_reg.sand_valid};

    // a held skid word always sits behind a held output word
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held without an output word");

    // a result arriving at a blocked output must be caught by the skid word
    a_skid_catch: assert property (@(posedge clk) disable iff (!rst_n)
        (ce && out_valid_reg && !m_axis_tready && res.valid) |=> skid_valid_reg)
        else $error("result dropped at blocked output");

    // coupled results carry both valid bits
    a_cohesion_both: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[2]) |-> (m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("cohesion without both phases");

    // an empty node gives an all-zero result
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0] && !m_axis_tuser[1])
        |-> (m_axis_tdata == '0 && !m_axis_tuser[3] && !m_axis_tuser[2]))
        else $error("empty node gave a nonzero result");

endmodule
